### hdl/nbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbl_pkg: shared types and constants of the nine-bit bus link
// Beat layouts, request codes and reset values used by the link core.
// ----------------------------------------------------------------------------
package nbl_pkg;

  localparam int MaxFrameBytes = 32;

  // request codes carried in the input tuser
  localparam logic [1:0] ReqEdge   = 2'd0;
  localparam logic [1:0] ReqSample = 2'd1;
  localparam logic [1:0] ReqTick   = 2'd2;
  localparam logic [1:0] ReqQueue  = 2'd3;

  localparam logic [4:0] BackoffBitsReset = 5'd10;
  localparam logic [3:0] NoBit            = 4'd15;
  localparam logic [7:0] RemainReset      = 8'd255;
  localparam logic [7:0] RemainLength     = 8'd254;
  localparam logic [7:0] LengthMask       = 8'h0F;

  typedef struct packed {
    logic [1:0] req_type;
    logic       line_bit;
    logic [7:0] queue_byte;
    logic       queue_last;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       drive_valid;
    logic       drive_level;
    logic       byte_valid;
    logic [7:0] byte_value;
    logic       byte_command;
    logic       datagram_end;
    logic       collision;
    logic       arm_transmitter;
  } result_t;

endpackage

### hdl/nbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/nbl_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbl_engine: receive, framing and transmit state of the link
// Updates the link state for one registered beat and forms its result.
// ----------------------------------------------------------------------------
module nbl_engine #(
  parameter int MAX_FRAME_BYTES = nbl_pkg::MaxFrameBytes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  nbl_pkg::item_t   item_i,
  output nbl_pkg::result_t res_o
);

  localparam int AW = $clog2(MAX_FRAME_BYTES);
  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [PW-1:0] FillMax = PW'(MAX_FRAME_BYTES);
  localparam logic [PW-1:0] One     = PW'(1);

  localparam logic [1:0] ModeIdle = 2'd0;
  localparam logic [1:0] ModeWait = 2'd1;
  localparam logic [1:0] ModeRecv = 2'd2;
  localparam logic [1:0] ModeXmit = 2'd3;

  logic [3:0]    rx_bit_q, rx_bit_d;
  logic [7:0]    rx_shift_q, rx_shift_d;
  logic          rx_cmd_q, rx_cmd_d;
  logic [7:0]    rx_rem_q, rx_rem_d;
  logic [3:0]    tx_bit_q, tx_bit_d;
  logic [7:0]    tx_cur_q, tx_cur_d;
  logic          tx_cmd_q, tx_cmd_d;
  logic [PW-1:0] tx_pos_q, tx_pos_d;
  logic [PW-1:0] tx_pend_q, tx_pend_d;
  logic [PW-1:0] tx_fill_q, tx_fill_d;
  logic [1:0]    mode_q, mode_d;

  logic [3:0]    rx_idx;
  logic [7:0]    shift_v;
  logic          cmd_v;
  logic [7:0]    rem_v;
  logic [PW-1:0] pend_v;
  logic [PW-1:0] fill_v;
  logic          wr_hit;
  nbl_pkg::result_t res;

  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;
  logic          byp_q;
  logic [7:0]    byp_data_q;
  logic [7:0]    store_rd;

  always_comb begin
    rx_bit_d   = rx_bit_q;
    rx_shift_d = rx_shift_q;
    rx_cmd_d   = rx_cmd_q;
    rx_rem_d   = rx_rem_q;
    tx_bit_d   = tx_bit_q;
    tx_cur_d   = tx_cur_q;
    tx_cmd_d   = tx_cmd_q;
    tx_pos_d   = tx_pos_q;
    tx_pend_d  = tx_pend_q;
    tx_fill_d  = tx_fill_q;
    mode_d     = mode_q;
    res        = '0;
    wr_hit     = 1'b0;
    rx_idx     = rx_bit_q + 4'd1;
    shift_v    = (rx_idx == 4'd0) ? 8'd0 : rx_shift_q;
    cmd_v      = (rx_idx == 4'd0) ? 1'b0 : rx_cmd_q;
    rem_v      = rx_cmd_q ? nbl_pkg::RemainReset : rx_rem_q;
    pend_v     = tx_pend_q;
    fill_v     = tx_fill_q;
    case (item_i.req_type)
      nbl_pkg::ReqEdge: begin
        if (rx_bit_q == nbl_pkg::NoBit) begin
          if (mode_q == ModeIdle || mode_q == ModeWait) begin
            mode_d = ModeRecv;
          end
          res.accepted = 1'b1;
        end
      end
      nbl_pkg::ReqSample: begin
        if (rx_idx <= 4'd7) begin
          rx_shift_d = shift_v;
          rx_shift_d[rx_idx[2:0]] = shift_v[rx_idx[2:0]] | item_i.line_bit;
          rx_cmd_d   = cmd_v;
          rx_bit_d   = rx_idx;
          res.accepted = 1'b1;
        end else if (rx_idx == 4'd8) begin
          rx_shift_d = shift_v;
          rx_cmd_d   = item_i.line_bit;
          rx_bit_d   = rx_idx;
          res.accepted = 1'b1;
        end else begin
          rx_bit_d = nbl_pkg::NoBit;
          if (!item_i.line_bit) begin
            // stop bit low: drop the character
            mode_d = ModeIdle;
          end else begin
            mode_d = ModeWait;
            if (mode_q == ModeXmit && rx_shift_q != tx_cur_q) begin
              // echo mismatch: cancel the datagram
              tx_pend_d           = '0;
              tx_pos_d            = '0;
              res.collision       = 1'b1;
              res.arm_transmitter = 1'b1;
            end else begin
              res.byte_valid   = 1'b1;
              res.byte_value   = rx_shift_q;
              res.byte_command = rx_cmd_q;
              rx_rem_d = rem_v;
              if (rem_v == nbl_pkg::RemainLength) begin
                rx_rem_d = rx_shift_q & nbl_pkg::LengthMask;
              end else if (rem_v == 8'd0) begin
                res.datagram_end = 1'b1;
              end else begin
                rx_rem_d = rem_v - 8'd1;
              end
              if (mode_q == ModeXmit) begin
                if (tx_pend_q != '0) begin
                  pend_v   = tx_pend_q - One;
                  tx_pos_d = tx_pos_q + One;
                end
                tx_pend_d = pend_v;
                res.arm_transmitter = (pend_v == '0);
              end else begin
                res.arm_transmitter = 1'b1;
              end
            end
          end
        end
      end
      nbl_pkg::ReqTick: begin
        if (tx_bit_q == nbl_pkg::NoBit) begin
          if (mode_q == ModeWait) begin
            mode_d = ModeIdle;
          end
          if (tx_pend_q != '0) begin
            tx_cur_d        = store_rd;
            tx_cmd_d        = (tx_pos_q == '0);
            mode_d          = ModeXmit;
            res.drive_valid = 1'b1;
            res.drive_level = 1'b0;
            tx_bit_d        = 4'd0;
          end
        end else if (tx_bit_q <= 4'd7) begin
          res.drive_valid = 1'b1;
          res.drive_level = tx_cur_q[tx_bit_q[2:0]];
          tx_bit_d        = tx_bit_q + 4'd1;
        end else if (tx_bit_q == 4'd8) begin
          res.drive_valid = 1'b1;
          res.drive_level = tx_cmd_q;
          tx_bit_d        = 4'd9;
        end else begin
          res.drive_valid = 1'b1;
          res.drive_level = 1'b1;
          tx_bit_d        = nbl_pkg::NoBit;
        end
      end
      nbl_pkg::ReqQueue: begin
        if (tx_pend_q == '0) begin
          if (tx_fill_q < FillMax) begin
            wr_hit       = 1'b1;
            fill_v       = tx_fill_q + One;
            res.accepted = 1'b1;
          end
          if (item_i.queue_last && fill_v != '0) begin
            tx_pend_d = fill_v;
            tx_pos_d  = '0;
            tx_fill_d = '0;
          end else begin
            tx_fill_d = fill_v;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  assign res_o     = res;
  assign ram_we    = fire_i & wr_hit;
  // keep the read port on the next transmit position
  assign ram_raddr = fire_i ? tx_pos_d[AW-1:0] : tx_pos_q[AW-1:0];
  assign store_rd  = byp_q ? byp_data_q : ram_rdata;

  nbl_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(tx_fill_q[AW-1:0]),
    .wdata_i(item_i.queue_byte),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // forward a byte written at the address being read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ram_we && (tx_fill_q[AW-1:0] == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= item_i.queue_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_bit_q   <= nbl_pkg::NoBit;
      rx_shift_q <= 8'd0;
      rx_cmd_q   <= 1'b0;
      rx_rem_q   <= nbl_pkg::RemainReset;
      tx_bit_q   <= nbl_pkg::NoBit;
      tx_cur_q   <= 8'd0;
      tx_cmd_q   <= 1'b1;
      tx_pos_q   <= '0;
      tx_pend_q  <= '0;
      tx_fill_q  <= '0;
      mode_q     <= ModeIdle;
    end else if (fire_i) begin
      rx_bit_q   <= rx_bit_d;
      rx_shift_q <= rx_shift_d;
      rx_cmd_q   <= rx_cmd_d;
      rx_rem_q   <= rx_rem_d;
      tx_bit_q   <= tx_bit_d;
      tx_cur_q   <= tx_cur_d;
      tx_cmd_q   <= tx_cmd_d;
      tx_pos_q   <= tx_pos_d;
      tx_pend_q  <= tx_pend_d;
      tx_fill_q  <= tx_fill_d;
      mode_q     <= mode_d;
    end
  end

endmodule

### hdl/nine_bit_bus_link_with_collision_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_bit_bus_link_with_collision_core: port of a shared nine-bit bus
// Receiver, datagram framing and collision-checked transmitter.
// ----------------------------------------------------------------------------
// Usage:
//   The s_axis channel takes one event per beat: tuser gives the request
//   (falling edge, receive sample, transmit tick, queue byte), tdata the
//   sampled line level and the queued byte, tlast the end of a queued
//   datagram. Each beat yields exactly one m_axis beat carrying the drive
//   request, the received byte, collision and rearm flags; tlast marks a
//   byte that completes a datagram and tuser carries its command bit.
//   The cfg channel writes backoff_bits, the bit-time wait that the external
//   transmit timer applies when arm_transmitter is set; backoff_bits_o
//   presents it to that timer. The cfg channel is always ready.
// Timing:
//   A beat is registered at the input, processed combinationally and held
//   in the result register; throughput is one beat per cycle while m_axis
//   does not stall. The transmit store is a RAM with registered read,
//   prefetched at the next transmit position.
//   Reset empties the store and returns the link to idle, no bit pending.
//   When m_axis stalls, the result and one input beat are held and
//   s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module nine_bit_bus_link_with_collision_core #(
  parameter int MAX_FRAME_BYTES = nbl_pkg::MaxFrameBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [0] line_bit, [8:1] queue_byte, [15:9] zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  input  logic        s_axis_tlast,  // queue_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] accepted, [1] drive_valid, [2] drive_level, [3] byte_valid,
  // [11:4] byte_value, [12] collision, [13] arm_transmitter, [15:14] zero
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tuser,  // byte_command
  output logic        m_axis_tlast,  // datagram_end
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i,
  output logic [4:0]  backoff_bits_o
);

  logic             in_valid_q;
  nbl_pkg::item_t   in_item_q;
  logic             res_valid_q;
  nbl_pkg::result_t res_q;
  nbl_pkg::result_t res;
  logic             advance;
  logic             fire;
  logic [4:0]       backoff_bits_q;

  assign advance       = !res_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backoff_bits_q <= nbl_pkg::BackoffBitsReset;
    end else if (cfg_valid_i) begin
      backoff_bits_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        res_valid_q <= in_valid_q;
      end
    end
  end

  // capture the beat and its result
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q.req_type   <= s_axis_tuser;
      in_item_q.line_bit   <= s_axis_tdata[0];
      in_item_q.queue_byte <= s_axis_tdata[8:1];
      in_item_q.queue_last <= s_axis_tlast;
    end
    if (fire) begin
      res_q <= res;
    end
  end

  nbl_engine #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_engine (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_item_q),
    .res_o (res)
  );

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {2'b00, res_q.arm_transmitter, res_q.collision, res_q.byte_value,
                          res_q.byte_valid, res_q.drive_level, res_q.drive_valid,
                          res_q.accepted};
  assign m_axis_tuser  = res_q.byte_command;
  assign m_axis_tlast  = res_q.datagram_end;

  // hand the wait to the external transmit timer, qualified by arm_transmitter
  assign backoff_bits_o = backoff_bits_q;

endmodule

### tb/sv/tb_nine_bit_bus_link_with_collision_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nine_bit_bus_link_with_collision_core: self-checking bench for the link
// A short directed table, then random received datagrams, echoed transmits
// with injected collisions and noise beats. Every result beat is compared
// against a cycle-free shadow of the link state. Both stream sides idle at
// random, and backoff_bits is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_nine_bit_bus_link_with_collision_core;

  localparam int CycleLimit = 1000000;
  localparam int PhaseItems = 240;
  localparam nbl_pkg::result_t ResNone   = '0;
  localparam nbl_pkg::result_t ResAccept = {1'b1, 15'd0};  // accepted alone

  typedef enum logic [1:0] {ModeIdle, ModeWait, ModeRecv, ModeXmit} link_mode_e;

  typedef struct packed {
    nbl_pkg::item_t   stim;
    logic             lit;
    nbl_pkg::result_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;  // [0] line_bit, [8:1] queue_byte, [15:9] zero
  logic [1:0]  s_axis_tuser;  // [1:0] req_type
  logic        s_axis_tlast;  // queue_last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [0] accepted, [1] drive_valid, [2] drive_level, [3] byte_valid,
  // [11:4] byte_value, [12] collision, [13] arm_transmitter, [15:14] zero
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;  // byte_command
  logic        m_axis_tlast;  // datagram_end
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i;
  logic [4:0]  backoff_bits_o;

  // shadow state of the link
  logic [4:0]  sh_backoff_bits;
  logic [3:0]  sh_rx_idx;
  logic [7:0]  sh_rx_shift;
  logic        sh_rx_cmd;
  logic [7:0]  sh_rx_remain;
  logic [3:0]  sh_tx_idx;
  logic [7:0]  sh_tx_cur;
  logic        sh_tx_cmd;
  logic [7:0]  sh_tx_store [nbl_pkg::MaxFrameBytes];
  int          sh_tx_pos;
  int          sh_tx_pend;
  int          sh_tx_fill;
  link_mode_e  sh_mode;

  nbl_pkg::result_t due_results [$];
  dir_row_t         dir_rows [$];

  int cycle_count = 0;
  int errors = 0;
  int items_sent = 0;
  int acted_items = 0;
  int results_seen = 0;
  int bytes_seen = 0;
  int ends_seen = 0;
  int collisions_seen = 0;
  int drives_seen = 0;
  logic tx_quiet = 1'b0;

  nine_bit_bus_link_with_collision_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .backoff_bits_o(backoff_bits_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic nbl_pkg::item_t mk_item(logic [1:0] req, logic lvl, logic [7:0] qb,
                                             logic ql);
    nbl_pkg::item_t it;
    it.req_type   = req;
    it.line_bit   = lvl;
    it.queue_byte = qb;
    it.queue_last = ql;
    return it;
  endfunction

  // Advance the shadow link by one event and return the result beat it yields.
  function automatic nbl_pkg::result_t predict_link(nbl_pkg::item_t it);
    nbl_pkg::result_t r;
    logic [3:0]       nidx;
    logic [7:0]       b;
    link_mode_e       prior;
    r = '0;
    case (it.req_type)
      nbl_pkg::ReqEdge: begin
        if (sh_rx_idx == nbl_pkg::NoBit) begin
          if (sh_mode == ModeIdle || sh_mode == ModeWait) sh_mode = ModeRecv;
          r.accepted = 1'b1;
        end
      end
      nbl_pkg::ReqSample: begin
        nidx = sh_rx_idx + 4'd1;
        if (nidx == 4'd0) begin
          sh_rx_shift = '0;
          sh_rx_cmd   = 1'b0;
        end
        if (nidx <= 4'd7) begin
          if (it.line_bit) sh_rx_shift[nidx[2:0]] = 1'b1;
          sh_rx_idx  = nidx;
          r.accepted = 1'b1;
        end else if (nidx == 4'd8) begin
          sh_rx_cmd  = it.line_bit;
          sh_rx_idx  = nidx;
          r.accepted = 1'b1;
        end else begin
          sh_rx_idx = nbl_pkg::NoBit;
          if (!it.line_bit) begin
            sh_mode = ModeIdle;
          end else begin
            prior   = sh_mode;
            b       = sh_rx_shift;
            sh_mode = ModeWait;
            if (prior == ModeXmit && b != sh_tx_cur) begin
              // echo differs from what went out: cancel the datagram
              sh_tx_pend        = 0;
              sh_tx_pos         = 0;
              r.collision       = 1'b1;
              r.arm_transmitter = 1'b1;
            end else begin
              if (sh_rx_cmd) sh_rx_remain = nbl_pkg::RemainReset;
              r.byte_valid   = 1'b1;
              r.byte_value   = b;
              r.byte_command = sh_rx_cmd;
              if (sh_rx_remain == nbl_pkg::RemainLength) sh_rx_remain = b & nbl_pkg::LengthMask;
              else if (sh_rx_remain == 8'd0) r.datagram_end = 1'b1;
              else sh_rx_remain = sh_rx_remain - 8'd1;
              if (prior == ModeXmit) begin
                if (sh_tx_pend > 0) begin
                  sh_tx_pend = sh_tx_pend - 1;
                  sh_tx_pos  = sh_tx_pos + 1;
                end
                r.arm_transmitter = (sh_tx_pend == 0);
              end else begin
                r.arm_transmitter = 1'b1;
              end
            end
          end
        end
      end
      nbl_pkg::ReqTick: begin
        if (sh_tx_idx == nbl_pkg::NoBit) begin
          if (sh_mode == ModeWait) sh_mode = ModeIdle;
          if (sh_tx_pend != 0) begin
            sh_tx_cur     = (sh_tx_pos < nbl_pkg::MaxFrameBytes) ? sh_tx_store[sh_tx_pos]
                                                                 : 8'd0;
            sh_tx_cmd     = (sh_tx_pos == 0);
            sh_mode       = ModeXmit;
            r.drive_valid = 1'b1;
            sh_tx_idx     = 4'd0;
          end
        end else if (sh_tx_idx <= 4'd7) begin
          r.drive_valid = 1'b1;
          r.drive_level = sh_tx_cur[sh_tx_idx[2:0]];
          sh_tx_idx     = sh_tx_idx + 4'd1;
        end else if (sh_tx_idx == 4'd8) begin
          r.drive_valid = 1'b1;
          r.drive_level = sh_tx_cmd;
          sh_tx_idx     = 4'd9;
        end else begin
          r.drive_valid = 1'b1;
          r.drive_level = 1'b1;
          sh_tx_idx     = nbl_pkg::NoBit;
        end
      end
      default: begin
        if (sh_tx_pend == 0) begin
          if (sh_tx_fill < nbl_pkg::MaxFrameBytes) begin
            sh_tx_store[sh_tx_fill] = it.queue_byte;
            sh_tx_fill = sh_tx_fill + 1;
            r.accepted = 1'b1;
          end
          // commit what was collected, overflow or not
          if (it.queue_last && sh_tx_fill > 0) begin
            sh_tx_pend = sh_tx_fill;
            sh_tx_pos  = 0;
            sh_tx_fill = 0;
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic string fmt_result(nbl_pkg::result_t r);
    return $sformatf("acc=%b dv=%b lvl=%b bv=%b val=%h cmd=%b end=%b col=%b arm=%b",
                     r.accepted, r.drive_valid, r.drive_level, r.byte_valid, r.byte_value,
                     r.byte_command, r.datagram_end, r.collision, r.arm_transmitter);
  endfunction

  task automatic flag_error(input string what, input nbl_pkg::result_t want,
                            input nbl_pkg::result_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch at cycle %0d, %s\n  expected %s\n  actual   %s",
               cycle_count, what, fmt_result(want), fmt_result(got));
  endtask

  // Hold the beat until accepted, then record what it should produce.
  task automatic send_item(input nbl_pkg::item_t it, input logic lit,
                           input nbl_pkg::result_t lit_res);
    int               gap;
    nbl_pkg::result_t pred;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, it.queue_byte, it.line_bit};
    s_axis_tuser  <= it.req_type;
    s_axis_tlast  <= it.queue_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_link(it);
    due_results.push_back(lit ? lit_res : pred);
    items_sent++;
    if (pred != ResNone) acted_items++;
  endtask

  task automatic send_rand(input logic [1:0] req, input logic lvl);
    send_item(mk_item(req, lvl, 8'($urandom), 1'($urandom)), 1'b0, ResNone);
  endtask

  task automatic add_row(input logic [1:0] req, input logic lvl, input logic [7:0] qb,
                         input logic ql, input logic lit, input nbl_pkg::result_t want);
    dir_row_t row;
    row.stim = mk_item(req, lvl, qb, ql);
    row.lit  = lit;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Finish any half-done character on either side.
  task automatic align_link();
    while (sh_rx_idx != nbl_pkg::NoBit) send_rand(nbl_pkg::ReqSample, 1'($urandom));
    while (sh_tx_idx != nbl_pkg::NoBit) send_rand(nbl_pkg::ReqTick, 1'b0);
  endtask

  task automatic rx_char(input logic [7:0] value, input logic cmd, input logic stop,
                         input logic with_edge);
    int i;
    if (with_edge) send_rand(nbl_pkg::ReqEdge, 1'($urandom));
    for (i = 0; i < 8; i++) send_rand(nbl_pkg::ReqSample, value[i]);
    send_rand(nbl_pkg::ReqSample, cmd);
    send_rand(nbl_pkg::ReqSample, stop);
  endtask

  task automatic rx_datagram();
    int         nib;
    int         i;
    int         total;
    logic [7:0] b;
    align_link();
    nib   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    // length byte says 3 + nibble; sometimes trail extra bytes without a command bit
    total = 3 + nib + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
    for (i = 0; i < total; i++) begin
      b = 8'($urandom);
      if (i == 1) b[3:0] = 4'(nib);
      rx_char(b, (i == 0) && ($urandom_range(0, 7) != 0), $urandom_range(0, 15) != 0,
              $urandom_range(0, 15) != 0);
    end
  endtask

  task automatic tx_datagram();
    int         n;
    int         i;
    int         k;
    logic       big;
    logic       corrupt;
    logic [7:0] echo;
    logic [9:0] frame;
    align_link();
    big = ($urandom_range(0, 9) == 0);
    n   = big ? $urandom_range(nbl_pkg::MaxFrameBytes + 1, nbl_pkg::MaxFrameBytes + 3)
              : $urandom_range(1, 4);
    for (i = 0; i < n; i++)
      send_item(mk_item(nbl_pkg::ReqQueue, 1'($urandom), 8'($urandom), i == n - 1), 1'b0,
                ResNone);
    k = 0;
    while (sh_tx_pend != 0) begin
      // an overflowed datagram is cut short by a collision on its first byte
      corrupt = big ? (k == 0) : ($urandom_range(0, 7) == 0);
      send_rand(nbl_pkg::ReqTick, 1'b0);
      echo  = sh_tx_cur ^ (corrupt ? (8'h01 << $urandom_range(0, 7)) : 8'h00);
      frame = {1'b1, sh_tx_cmd, echo};
      send_rand(nbl_pkg::ReqEdge, 1'b0);
      for (i = 0; i < 10; i++) begin
        send_rand(nbl_pkg::ReqTick, 1'b0);
        send_rand(nbl_pkg::ReqSample, frame[i]);
      end
      if ($urandom_range(0, 7) == 0) send_rand(nbl_pkg::ReqQueue, 1'b0);
      k++;
    end
  endtask

  task automatic noise();
    int i;
    int n;
    n = $urandom_range(1, 5);
    for (i = 0; i < n; i++)
      send_item(mk_item(2'($urandom), 1'($urandom), 8'($urandom), 1'($urandom)), 1'b0,
                ResNone);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_backoff_bits(input logic [4:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i     <= 1'b0;
    sh_backoff_bits = value;
  endtask

  // receiver: runs of ready broken by stalls, now and then a long clean run
  initial begin : sink_p
    int run;
    int stall;
    logic quiet;
    m_axis_tready <= 1'b0;
    repeat (12) @(posedge clk_i);
    forever begin
      quiet = ($urandom_range(0, 5) == 0);
      run   = quiet ? 150 : $urandom_range(1, 30);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap(1'b0);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_p
    nbl_pkg::result_t got;
    nbl_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.accepted        = m_axis_tdata[0];
      got.drive_valid     = m_axis_tdata[1];
      got.drive_level     = m_axis_tdata[2];
      got.byte_valid      = m_axis_tdata[3];
      got.byte_value      = m_axis_tdata[11:4];
      got.collision       = m_axis_tdata[12];
      got.arm_transmitter = m_axis_tdata[13];
      got.byte_command    = m_axis_tuser;
      got.datagram_end    = m_axis_tlast;
      results_seen++;
      if (got.byte_valid) bytes_seen++;
      if (got.datagram_end) ends_seen++;
      if (got.collision) collisions_seen++;
      if (got.drive_valid) drives_seen++;
      if (due_results.size() == 0) begin
        flag_error("result beat with nothing outstanding", ResNone, got);
      end else begin
        want = due_results.pop_front();
        if (got !== want) flag_error($sformatf("result %0d", results_seen), want, got);
      end
      if (backoff_bits_o !== sh_backoff_bits) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at cycle %0d, backoff_bits_o expected %0d actual %0d",
                   cycle_count, sh_backoff_bits, backoff_bits_o);
      end
    end
  end

  initial begin : main_p
    int          i;
    int          ph;
    int          target;
    logic [4:0]  backoff_plan [4];
    backoff_plan[0] = 5'd1;
    backoff_plan[1] = 5'($urandom_range(2, 30));
    backoff_plan[2] = 5'd31;
    backoff_plan[3] = nbl_pkg::BackoffBitsReset;

    sh_backoff_bits = nbl_pkg::BackoffBitsReset;
    sh_rx_idx    = nbl_pkg::NoBit;
    sh_rx_shift  = '0;
    sh_rx_cmd    = 1'b0;
    sh_rx_remain = nbl_pkg::RemainReset;
    sh_tx_idx    = nbl_pkg::NoBit;
    sh_tx_cur    = '0;
    sh_tx_cmd    = 1'b1;
    sh_tx_pos    = 0;
    sh_tx_pend   = 0;
    sh_tx_fill   = 0;
    sh_mode      = ModeIdle;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= nbl_pkg::ReqEdge;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    write_backoff_bits(5'd31);

    add_row(nbl_pkg::ReqTick, 1'b0, 8'h00, 1'b0, 1'b1, ResNone);    // nothing queued: no drive
    add_row(nbl_pkg::ReqSample, 1'b1, 8'hFF, 1'b1, 1'b1, ResAccept); // no edge: data bit 0
    add_row(nbl_pkg::ReqEdge, 1'b0, 8'h00, 1'b0, 1'b1, ResNone);    // edge inside a character
    for (i = 1; i < 8; i++) add_row(nbl_pkg::ReqSample, 1'b1, 8'h00, 1'b0, 1'b0, ResNone);
    add_row(nbl_pkg::ReqSample, 1'b1, 8'h00, 1'b0, 1'b0, ResNone);
    add_row(nbl_pkg::ReqSample, 1'b0, 8'h00, 1'b0, 1'b1, ResNone);  // low stop bit: dropped
    add_row(nbl_pkg::ReqEdge, 1'b1, 8'hFF, 1'b1, 1'b1, ResAccept);
    for (i = 0; i < 8; i++) add_row(nbl_pkg::ReqSample, 1'b0, 8'hFF, 1'b1, 1'b0, ResNone);
    add_row(nbl_pkg::ReqSample, 1'b0, 8'h00, 1'b0, 1'b0, ResNone);
    add_row(nbl_pkg::ReqSample, 1'b1, 8'h00, 1'b0, 1'b0, ResNone);
    add_row(nbl_pkg::ReqQueue, 1'b0, 8'hFF, 1'b0, 1'b1, ResAccept);
    add_row(nbl_pkg::ReqQueue, 1'b1, 8'h00, 1'b1, 1'b1, ResAccept);
    add_row(nbl_pkg::ReqQueue, 1'b0, 8'h5A, 1'b1, 1'b1, ResNone);   // datagram pending: rejected
    add_row(nbl_pkg::ReqTick, 1'b0, 8'h00, 1'b0, 1'b0, ResNone);
    for (i = 0; i < dir_rows.size(); i++)
      send_item(dir_rows[i].stim, dir_rows[i].lit, dir_rows[i].want);

    target = items_sent;
    for (ph = 0; ph < 4; ph++) begin
      drain_results();
      write_backoff_bits(backoff_plan[ph]);
      target = target + PhaseItems;
      while (items_sent < target) begin
        i = $urandom_range(0, 9);
        if (i < 4) rx_datagram();
        else if (i < 8) tx_datagram();
        else noise();
        if ($urandom_range(0, 4) == 0) tx_quiet = !tx_quiet;
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d events (%0d with a nonzero result) over four backoff settings,",
             items_sent, acted_items);
    $display("  %0d result beats checked: %0d bytes received, %0d datagram ends, %0d collisions, %0d drive beats",
             results_seen, bytes_seen, ends_seen, collisions_seen, drives_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### nine_bit_bus_link_with_collision_core.f
hdl/nbl_pkg.sv
hdl/nbl_ram.sv
hdl/nbl_engine.sv
hdl/nine_bit_bus_link_with_collision_core.sv
tb/sv/tb_nine_bit_bus_link_with_collision_core.sv
